// ===== design/szst_pkg.sv =====
`timescale 1ns / 1ps

package szst_pkg;

  localparam int unsigned RawWidth  = 12;
  localparam int unsigned TickWidth = 32;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 12;

  localparam logic [RawWidth-1:0]  OpenThresholdReset  = 12'd3000;
  localparam logic [RawWidth-1:0]  CloseThresholdReset = 12'd1000;
  localparam logic [RawWidth-1:0]  RawMax              = 12'd4095;
  localparam logic [ByteWidth-1:0] ByteMax             = 8'd255;

  localparam logic [RawWidth:0]    ZoneHysteresis = 13'd10;
  localparam logic [RawWidth:0]    SlideStep      = 13'd100;
  localparam logic [TickWidth-1:0] SlideTimeoutMs = 32'd1000;
  localparam logic [ByteWidth-1:0] FadeLength     = 8'd32;
  localparam logic [ByteWidth-1:0] FadePeak       = 8'd255;

  // raw*255/4095 == raw*17/273
  localparam logic [8:0] ByteNum = 9'd17;
  localparam logic [8:0] ByteDen = 9'd273;

  typedef enum logic [1:0] {
    ZN_MIDDLE = 2'd0,
    ZN_OPEN   = 2'd1,
    ZN_CLOSED = 2'd2,
    ZN_NONE   = 2'd3
  } zone_t;

  typedef enum logic [1:0] {
    FK_LEVEL = 2'd0,
    FK_RED   = 2'd1,
    FK_GREEN = 2'd2
  } fade_kind_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_OPEN_THRESHOLD   = 2'd0,
    CFG_CLOSE_THRESHOLD  = 2'd1,
    CFG_RISING_DIRECTION = 2'd2,
    CFG_AUTO_REPORT      = 2'd3
  } cfg_index_t;

  function automatic zone_t classify(input logic [RawWidth-1:0] pos,
                                     input logic [RawWidth-1:0] open_th,
                                     input logic [RawWidth-1:0] close_th);
    zone_t z;
    if (pos >= open_th) begin
      z = ZN_OPEN;
    end else if (pos <= close_th) begin
      z = ZN_CLOSED;
    end else begin
      z = ZN_MIDDLE;
    end
    return z;
  endfunction

endpackage

// ===== design/slider_zone_and_slip_tracker_core.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Handshake             | Payload
// in_     | input     | in_valid / in_stall   | raw_reading, tick_ms
// out_    | output    | out_valid / out_stall | positions, status, zone, overlay
// cfg_    | input     | cfg_we                | cfg_index, cfg_data
//
// One request per cycle while in_stall is low; a result is offered once its request has passed
// through the input register and then the result register.
// Zone, slip and status state update when a request moves into the result register.
// out_stall holds the result register; once the input register is also full it holds
// and in_stall rises.
// Synchronous active-low reset clears control state and restores the default configuration.

module slider_zone_and_slip_tracker_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [szst_pkg::RawWidth-1:0]         in_raw_reading,
  input  logic [szst_pkg::TickWidth-1:0]        in_tick_ms,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [szst_pkg::RawWidth-1:0]         out_position_wide,
  output logic [szst_pkg::ByteWidth-1:0]        out_position_byte,
  output logic                                  out_switch_open,
  output logic                                  out_report_change,
  output logic [1:0]                            out_zone,
  output logic                                  out_fade_start,
  output logic                                  out_overlay_write,
  output logic [1:0]                            out_fade_kind,
  output logic [szst_pkg::ByteWidth-1:0]        out_fade_frames,
  output logic [szst_pkg::ByteWidth-1:0]        out_red_level,
  output logic [szst_pkg::ByteWidth-1:0]        out_green_level,
  input  logic                                  cfg_we,
  input  logic [szst_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [szst_pkg::CfgDataWidth-1:0]     cfg_data
);

  localparam int unsigned RW = szst_pkg::RawWidth;
  localparam int unsigned TW = szst_pkg::TickWidth;
  localparam int unsigned BW = szst_pkg::ByteWidth;

  logic [RW-1:0] open_th_r;
  logic [RW-1:0] close_th_r;
  logic          rising_r;
  logic          auto_r;

  logic          s1_valid_r;
  logic [RW-1:0] s1_raw_r;
  logic [TW-1:0] s1_tick_r;

  szst_pkg::zone_t zone_r, zone_nxt;
  logic            track_r, track_nxt;
  logic [RW-1:0]   ref_val_r, ref_val_nxt;
  logic [TW-1:0]   ref_time_r, ref_time_nxt;
  logic            status_r;

  logic          out_valid_r;
  logic [RW-1:0] pos_r;
  logic [BW-1:0] pbyte_r;
  logic          swo_r;
  logic          rchg_r;
  logic [1:0]    zone_out_r;
  logic          fstart_r;
  logic          owrite_r;
  logic [1:0]    kind_r;
  logic [BW-1:0] frames_r;
  logic [BW-1:0] red_r;
  logic [BW-1:0] green_r;

  logic          move;
  logic          in_acc;

  logic [RW-1:0]  pos;
  logic [BW-1:0]  q_est;
  logic [16:0]    q_lhs;
  logic [16:0]    q_rhs;
  logic [BW-1:0]  pbyte_up;
  logic [BW-1:0]  pbyte;
  logic [BW-1:0]  lvl;
  logic [RW:0]    pos_x;
  logic [TW-1:0]  elapsed;
  logic           in_time;
  logic           fstart;
  logic           owrite;
  logic [1:0]     kind;
  logic [BW-1:0]  frames;
  logic [BW-1:0]  red;
  logic [BW-1:0]  green;
  logic           newstat;

  assign move     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !move;
  assign in_acc   = in_valid && !in_stall;

  // position and byte scale
  always_comb begin
    q_est    = s1_raw_r[RW-1:RW-BW];
    q_lhs    = 17'(q_est) * 17'(szst_pkg::ByteDen);
    q_rhs    = 17'(s1_raw_r) * 17'(szst_pkg::ByteNum);
    pbyte_up = (q_lhs <= q_rhs) ? q_est : q_est - 8'd1;
    if (rising_r) begin
      pos   = s1_raw_r;
      pbyte = pbyte_up;
    end else begin
      pos   = szst_pkg::RawMax - s1_raw_r;
      pbyte = szst_pkg::ByteMax - pbyte_up;
    end
    pos_x   = {1'b0, pos};
    lvl     = pos[RW-1:RW-BW];
    elapsed = s1_tick_r - ref_time_r;
    in_time = elapsed <= szst_pkg::SlideTimeoutMs;
    newstat = pos > close_th_r;
  end

  // zone machine and overlay
  always_comb begin
    zone_nxt     = zone_r;
    track_nxt    = track_r;
    ref_val_nxt  = ref_val_r;
    ref_time_nxt = ref_time_r;
    fstart       = 1'b0;
    owrite       = 1'b0;
    kind         = szst_pkg::FK_LEVEL;
    frames       = '0;
    red          = '0;
    green        = '0;

    unique case (zone_r)
      szst_pkg::ZN_OPEN: begin
        if (pos_x + szst_pkg::ZoneHysteresis < {1'b0, open_th_r}) begin
          fstart   = 1'b1;
          zone_nxt = szst_pkg::classify(pos, open_th_r, close_th_r);
        end
      end
      szst_pkg::ZN_CLOSED: begin
        if (pos_x > {1'b0, close_th_r} + szst_pkg::ZoneHysteresis) begin
          fstart   = 1'b1;
          zone_nxt = szst_pkg::classify(pos, open_th_r, close_th_r);
        end
      end
      default: begin
        zone_nxt = szst_pkg::classify(pos, open_th_r, close_th_r);
        fstart   = zone_nxt != szst_pkg::ZN_MIDDLE;
      end
    endcase

    if (auto_r) begin
      if (zone_nxt == szst_pkg::ZN_CLOSED) begin
        if (fstart) begin
          owrite = 1'b1;
          kind   = szst_pkg::FK_RED;
          frames = szst_pkg::FadeLength;
          red    = szst_pkg::FadePeak;
        end
      end else if (zone_nxt == szst_pkg::ZN_OPEN) begin
        if (fstart) begin
          owrite = 1'b1;
          kind   = szst_pkg::FK_GREEN;
          frames = szst_pkg::FadeLength;
          green  = szst_pkg::FadePeak;
        end
      end else if (!track_r) begin
        track_nxt    = 1'b1;
        ref_time_nxt = s1_tick_r;
        ref_val_nxt  = pos;
      end else if (pos_x > {1'b0, ref_val_r} + szst_pkg::SlideStep && in_time) begin
        owrite       = 1'b1;
        green        = lvl;
        ref_val_nxt  = pos;
        ref_time_nxt = s1_tick_r;
      end else if (pos_x + szst_pkg::SlideStep < {1'b0, ref_val_r} && in_time) begin
        owrite       = 1'b1;
        red          = szst_pkg::ByteMax - lvl;
        ref_val_nxt  = pos;
        ref_time_nxt = s1_tick_r;
      end else if (!in_time) begin
        owrite    = 1'b1;
        track_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_th_r   <= szst_pkg::OpenThresholdReset;
      close_th_r  <= szst_pkg::CloseThresholdReset;
      rising_r    <= 1'b1;
      auto_r      <= 1'b1;
      s1_valid_r  <= 1'b0;
      zone_r      <= szst_pkg::ZN_NONE;
      track_r     <= 1'b0;
      ref_val_r   <= '0;
      ref_time_r  <= '0;
      status_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (szst_pkg::cfg_index_t'(cfg_index))
          szst_pkg::CFG_OPEN_THRESHOLD:   open_th_r  <= cfg_data[RW-1:0];
          szst_pkg::CFG_CLOSE_THRESHOLD:  close_th_r <= cfg_data[RW-1:0];
          szst_pkg::CFG_RISING_DIRECTION: rising_r   <= cfg_data[0];
          szst_pkg::CFG_AUTO_REPORT:      auto_r     <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (move) begin
        s1_valid_r <= 1'b0;
      end
      if (move) begin
        zone_r      <= zone_nxt;
        track_r     <= track_nxt;
        ref_val_r   <= ref_val_nxt;
        ref_time_r  <= ref_time_nxt;
        status_r    <= newstat;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_raw_r  <= in_raw_reading;
      s1_tick_r <= in_tick_ms;
    end
    if (move) begin
      pos_r      <= pos;
      pbyte_r    <= pbyte;
      swo_r      <= newstat;
      rchg_r     <= (newstat != status_r) && auto_r;
      zone_out_r <= zone_nxt;
      fstart_r   <= fstart;
      owrite_r   <= owrite;
      kind_r     <= kind;
      frames_r   <= frames;
      red_r      <= red;
      green_r    <= green;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_position_wide = pos_r;
  assign out_position_byte = pbyte_r;
  assign out_switch_open   = swo_r;
  assign out_report_change = rchg_r;
  assign out_zone          = zone_out_r;
  assign out_fade_start    = fstart_r;
  assign out_overlay_write = owrite_r;
  assign out_fade_kind     = kind_r;
  assign out_fade_frames   = frames_r;
  assign out_red_level     = red_r;
  assign out_green_level   = green_r;

endmodule
